[hdl/wfea_pkg.sv]
// shared constants, types and codes for the worst-fit extent allocator
package wfea_pkg;

	localparam int MaxExtents = 16;
	localparam int AddrBits   = 32;
	localparam int LenBits    = 32;
	localparam int HdrBits    = 4;
	localparam int IdxBits    = $clog2(MaxExtents);
	localparam int CntBits    = $clog2(MaxExtents + 1);
	localparam int EndBits    = AddrBits + 1;
	localparam int WideBits   = (EndBits > LenBits + 1) ? EndBits : LenBits + 1;

	localparam logic [HdrBits-1:0]  HdrReset = HdrBits'(4);
	localparam logic [WideBits-1:0] LenMax   = WideBits'({LenBits{1'b1}});
	localparam logic [CntBits-1:0]  CntFull  = CntBits'(MaxExtents);

	typedef enum logic [1:0] {
		STAT_GRANTED = 2'd0,
		STAT_NOFIT   = 2'd1,
		STAT_FREED   = 2'd2,
		STAT_FULL    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLIP,
		S_KEY,
		S_SCAN,
		S_MERGE_L,
		S_MERGE_R,
		S_PLACE,
		S_ALLOC_EVAL,
		S_ALLOC_UPD,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic end_hit;
		logic start_hit;
		logic better;
	} scan_res_t;

	typedef struct packed {
		logic               we;
		logic [IdxBits-1:0] widx;
		logic [IdxBits-1:0] ridx;
	} tbl_ctrl_t;

endpackage

[hdl/wfea_table.sv]
// extent table: start and length register file, one write and one read index
module wfea_table (
	input  logic                           clk,
	input  wfea_pkg::tbl_ctrl_t            ctrl,
	input  logic [wfea_pkg::AddrBits-1:0]  wstart,
	input  logic [wfea_pkg::LenBits-1:0]   wlen,
	output logic [wfea_pkg::AddrBits-1:0]  rstart,
	output logic [wfea_pkg::LenBits-1:0]   rlen
);
	import wfea_pkg::*;

	logic [AddrBits-1:0] start_q [MaxExtents];
	logic [LenBits-1:0]  len_q   [MaxExtents];

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			start_q[ctrl.widx] <= wstart;
			len_q[ctrl.widx]   <= wlen;
		end
	end

	assign rstart = start_q[ctrl.ridx];
	assign rlen   = len_q[ctrl.ridx];

endmodule

[hdl/wfea_scan_unit.sv]
// per-entry compare unit: adjacency against the key and worst-fit ranking
module wfea_scan_unit (
	input  logic [wfea_pkg::AddrBits-1:0]  ent_start,
	input  logic [wfea_pkg::LenBits-1:0]   ent_len,
	input  logic [wfea_pkg::WideBits-1:0]  key_lo,
	input  logic [wfea_pkg::WideBits-1:0]  key_hi,
	input  logic                           best_hit,
	input  logic [wfea_pkg::AddrBits-1:0]  best_start,
	input  logic [wfea_pkg::LenBits-1:0]   best_len,
	output wfea_pkg::scan_res_t            res
);
	import wfea_pkg::*;

	logic [WideBits-1:0] ent_end;

	// end of the entry, one bit wider than an address
	assign ent_end = WideBits'(ent_start) + WideBits'(ent_len);

	assign res.end_hit   = (ent_end == key_lo);
	assign res.start_hit = (WideBits'(ent_start) == key_hi);
	// longer wins, equal length goes to the lower start
	assign res.better    = !best_hit || (ent_len > best_len) ||
		((ent_len == best_len) && (ent_start < best_start));

endmodule

[hdl/worst_fit_extent_allocator.sv]
// top level: sequencer, working registers and output register of the allocator
//
//  channel | dir | beat fields (lowest bit first)
//  s_*     | in  | tuser: mode ; tdata: extent_address[31:0], byte_length[63:32]
//  m_*     | out | tuser: status ; tdata: granted_address[31:0]
//  cfg_*   | in  | data: header_bytes[3:0]
//
// one beat at a time, taken only while the sequencer is idle
// free: clip, key, scan, merge left, merge right, place, then shift when the free joins two stored extents, then done
// allocate: scan, evaluate, update, then shift when the chosen extent empties, then done
// the table scan reads one entry a cycle through the compare unit
// reset empties the table and sets header_bytes to 4; no clearing pass
// a result not yet taken holds the sequencer in its final step
module worst_fit_extent_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	// input beats
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [63:0]                   s_tdata,   // extent_address, byte_length
	input  logic                          s_tuser,   // mode
	// result beats
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // granted_address
	output logic [1:0]                    m_tuser,   // status
	// header size register
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wfea_pkg::HdrBits-1:0]  cfg_data
);
	import wfea_pkg::*;

	state_t state_q, state_d;

	logic [HdrBits-1:0]  hdr_q;
	logic                mode_q;
	logic [AddrBits-1:0] addr_q;
	// working length: clipped free length, running merged length, or full request, then remainder
	logic [WideBits-1:0] len_q;
	// end of the freed extent, or the full request on allocate
	logic [WideBits-1:0] key_q;
	logic [CntBits-1:0]  cnt_q;
	logic [CntBits-1:0]  idx_q;

	// merge partners and worst-fit candidate found by the scan
	logic                left_hit_q, right_hit_q, best_hit_q;
	logic [IdxBits-1:0]  left_idx_q, right_idx_q, best_idx_q;
	logic [AddrBits-1:0] left_start_q, best_start_q;
	logic [LenBits-1:0]  left_len_q, right_len_q, best_len_q;

	// placement of the merged extent
	logic                dest_hit_q, drop_q;
	logic [IdxBits-1:0]  dest_idx_q, drop_idx_q;
	logic [AddrBits-1:0] cs_q;

	status_t             status_q;
	logic [31:0]         grant_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [31:0]         out_grant_q;

	tbl_ctrl_t           tctl;
	logic [AddrBits-1:0] wr_start, rd_start;
	logic [LenBits-1:0]  wr_len, rd_len;
	scan_res_t           sres;

	logic                in_beat, out_free, scan_end, shift_end, place_full;
	logic [CntBits-1:0]  idx_nxt;
	logic [WideBits-1:0] room, sum_l, sum_r, new_start;
	logic [WideBits:0]   diff;
	logic                merge_l_ok, merge_r_ok, fit;

	wfea_table u_table (
		.clk    (clk),
		.ctrl   (tctl),
		.wstart (wr_start),
		.wlen   (wr_len),
		.rstart (rd_start),
		.rlen   (rd_len)
	);

	wfea_scan_unit u_scan (
		.ent_start  (rd_start),
		.ent_len    (rd_len),
		.key_lo     (WideBits'(addr_q)),
		.key_hi     (key_q),
		.best_hit   (best_hit_q),
		.best_start (best_start_q),
		.best_len   (best_len_q),
		.res        (sres)
	);

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_beat   = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_grant_q;
	assign m_tuser  = out_status_q;

	// shared arithmetic of the sequencer steps
	assign idx_nxt    = idx_q + CntBits'(1);
	assign scan_end   = (idx_q == cnt_q);
	assign shift_end  = (idx_nxt >= cnt_q);
	assign place_full = !dest_hit_q && (cnt_q >= CntFull);
	assign room       = (WideBits'(1) << AddrBits) - WideBits'(addr_q);
	assign sum_l      = WideBits'(left_len_q) + len_q;
	assign sum_r      = len_q + WideBits'(right_len_q);
	assign merge_l_ok = left_hit_q && (sum_l <= LenMax);
	// a slot already joined on the left side cannot join again on the right
	assign merge_r_ok = right_hit_q && !(dest_hit_q && (right_idx_q == dest_idx_q)) &&
		(sum_r <= LenMax);
	assign diff       = {1'b0, WideBits'(best_len_q)} - {1'b0, len_q};
	assign fit        = best_hit_q && !diff[WideBits];
	assign new_start  = WideBits'(best_start_q) + key_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					state_d = s_tuser ? S_SCAN : S_CLIP;
				end
			end
			S_CLIP:    state_d = S_KEY;
			S_KEY:     state_d = (len_q == '0) ? S_DONE : S_SCAN;
			S_SCAN: begin
				if (scan_end) begin
					state_d = mode_q ? S_ALLOC_EVAL : S_MERGE_L;
				end
			end
			S_MERGE_L: state_d = S_MERGE_R;
			S_MERGE_R: state_d = S_PLACE;
			S_PLACE:   state_d = (dest_hit_q && drop_q) ? S_SHIFT : S_DONE;
			S_ALLOC_EVAL: state_d = fit ? S_ALLOC_UPD : S_DONE;
			S_ALLOC_UPD:  state_d = (len_q == '0) ? S_SHIFT : S_DONE;
			S_SHIFT: begin
				if (shift_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// table port control
	always_comb begin
		tctl.we   = 1'b0;
		tctl.widx = dest_idx_q;
		tctl.ridx = idx_q[IdxBits-1:0];
		wr_start  = cs_q;
		wr_len    = len_q[LenBits-1:0];
		case (state_q)
			S_PLACE: begin
				if (dest_hit_q) begin
					tctl.we = 1'b1;
				end else if (!place_full) begin
					tctl.we   = 1'b1;
					tctl.widx = cnt_q[IdxBits-1:0];
				end
			end
			S_ALLOC_UPD: begin
				// shrink the chosen extent from the front unless it empties
				tctl.we   = (len_q != '0);
				tctl.widx = best_idx_q;
				wr_start  = AddrBits'(new_start);
			end
			S_SHIFT: begin
				// close the gap: slot j takes slot j+1
				tctl.ridx = idx_nxt[IdxBits-1:0];
				tctl.we   = !shift_end;
				tctl.widx = idx_q[IdxBits-1:0];
				wr_start  = rd_start;
				wr_len    = rd_len;
			end
			default: begin
				tctl.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hdr_q   <= HdrReset;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				hdr_q <= cfg_data;
			end
			if ((state_q == S_PLACE) && !dest_hit_q && !place_full) begin
				cnt_q <= cnt_q + CntBits'(1);
			end else if ((state_q == S_SHIFT) && shift_end) begin
				cnt_q <= cnt_q - CntBits'(1);
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_beat) begin
					mode_q      <= s_tuser;
					addr_q      <= AddrBits'(s_tdata[31:0]);
					left_hit_q  <= 1'b0;
					right_hit_q <= 1'b0;
					best_hit_q  <= 1'b0;
					idx_q       <= '0;
					if (s_tuser) begin
						len_q <= WideBits'(s_tdata[63:32]) + WideBits'(hdr_q);
						key_q <= WideBits'(s_tdata[63:32]) + WideBits'(hdr_q);
					end else begin
						len_q <= WideBits'(s_tdata[63:32]);
					end
				end
			end
			S_CLIP: begin
				// cut a free that runs past the top of the address space
				if (len_q > room) begin
					len_q <= room;
				end
			end
			S_KEY: begin
				key_q    <= WideBits'(addr_q) + len_q;
				status_q <= STAT_FREED;
				grant_q  <= '0;
			end
			S_SCAN: begin
				if (!scan_end) begin
					idx_q <= idx_nxt;
					if (sres.end_hit && !left_hit_q) begin
						left_hit_q   <= 1'b1;
						left_idx_q   <= idx_q[IdxBits-1:0];
						left_start_q <= rd_start;
						left_len_q   <= rd_len;
					end
					if (sres.start_hit && !right_hit_q) begin
						right_hit_q <= 1'b1;
						right_idx_q <= idx_q[IdxBits-1:0];
						right_len_q <= rd_len;
					end
					if (sres.better) begin
						best_hit_q   <= 1'b1;
						best_idx_q   <= idx_q[IdxBits-1:0];
						best_start_q <= rd_start;
						best_len_q   <= rd_len;
					end
				end
			end
			S_MERGE_L: begin
				drop_q <= 1'b0;
				if (merge_l_ok) begin
					cs_q       <= left_start_q;
					len_q      <= sum_l;
					dest_hit_q <= 1'b1;
					dest_idx_q <= left_idx_q;
				end else begin
					cs_q       <= addr_q;
					dest_hit_q <= 1'b0;
				end
			end
			S_MERGE_R: begin
				if (merge_r_ok) begin
					len_q <= sum_r;
					if (!dest_hit_q) begin
						dest_hit_q <= 1'b1;
						dest_idx_q <= right_idx_q;
					end else begin
						drop_q     <= 1'b1;
						drop_idx_q <= right_idx_q;
					end
				end
			end
			S_PLACE: begin
				status_q <= place_full ? STAT_FULL : STAT_FREED;
				grant_q  <= '0;
				idx_q    <= {{(CntBits-IdxBits){1'b0}}, drop_idx_q};
			end
			S_ALLOC_EVAL: begin
				if (fit) begin
					status_q <= STAT_GRANTED;
					grant_q  <= 32'(best_start_q);
					len_q    <= diff[WideBits-1:0];
				end else begin
					status_q <= STAT_NOFIT;
					grant_q  <= '0;
				end
			end
			S_ALLOC_UPD: begin
				idx_q <= {{(CntBits-IdxBits){1'b0}}, best_idx_q};
			end
			S_SHIFT: begin
				if (!shift_end) begin
					idx_q <= idx_nxt;
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_status_q <= status_q;
			out_grant_q  <= grant_q;
		end
	end

	// the extent count never passes the table size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntFull)
		else $error("extent count beyond table size");

	// writes keep the table packed from slot 0
	a_wr_packed: assert property (@(posedge clk) disable iff (!arst_n)
		tctl.we |-> ({{(CntBits-IdxBits){1'b0}}, tctl.widx} <= cnt_q) &&
		(cnt_q < CntFull || {{(CntBits-IdxBits){1'b0}}, tctl.widx} < cnt_q))
		else $error("table write outside the packed range");

	// table full is only reported with every slot taken
	a_full_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && status_q == STAT_FULL) |-> cnt_q == CntFull)
		else $error("table full reported with free slots");

	// a grant is loaded only after a fitting scan
	a_grant_src: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ALLOC_UPD) |-> $past(state_q == S_ALLOC_EVAL) && best_hit_q)
		else $error("grant without a worst-fit candidate");

endmodule
